[rtl/dpps_pkg.sv]
package dpps_pkg;

   localparam int SLOT_W      = 6;
   localparam int GROUP_W     = 4;
   localparam int NUM_GROUPS  = 16;
   localparam int COUNT_OUT_W = 7;

   typedef struct packed {
      logic               valid;
      logic [SLOT_W-1:0]  slot;
      logic [GROUP_W-1:0] group;
      logic [31:0]        delay;
      logic [31:0]        power;
      logic [7:0]         driven_cap;
      logic [7:0]         out_slew;
      logic [7:0]         load_cap;
      logic [7:0]         in_slew;
      logic [31:0]        pattern;
   } entry_type;

   typedef struct packed {
      logic load;
      logic rotate;
      logic clear;
   } cell_ctrl_type;

   // front order: power, delay, three keys ascending, in_slew descending,
   // pattern, then load slot
   function automatic logic goes_before(entry_type a, entry_type b);
      logic r;
      if (a.power != b.power)                r = a.power < b.power;
      else if (a.delay != b.delay)           r = a.delay < b.delay;
      else if (a.driven_cap != b.driven_cap) r = a.driven_cap < b.driven_cap;
      else if (a.out_slew != b.out_slew)     r = a.out_slew < b.out_slew;
      else if (a.load_cap != b.load_cap)     r = a.load_cap < b.load_cap;
      else if (a.in_slew != b.in_slew)       r = a.in_slew > b.in_slew;
      else if (a.pattern != b.pattern)       r = a.pattern < b.pattern;
      else                                   r = a.slot < b.slot;
      return r;
   endfunction

endpackage

[rtl/delay_power_pareto_selector.sv]
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | delay, power, four keys, pattern, group, last
// rsp     | out       | rsp_valid/rsp_stall | slot, group, delay, power, count, least, last
// csr     | in        | csr_wr_en           | select_mode
//
// Entries load into an insertion-sorted chain of cells, one beat per cycle while loading.
// After the last entry the chain rotates through a full turn per pass:
// a count pass then an emit pass, once in mode 0 and once per group in
// mode 1, for up to MAX_GROUPS groups.
// Reset is synchronous and clears control state and the chain valid bits; entry data needs no clearing.
// A stalled result holds the chain rotation in the emit pass; req is stalled during the run.
module delay_power_pareto_selector #(
   parameter int MAX_ENTRIES = 64,
   parameter int MAX_GROUPS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_delay,
   input  logic [31:0] req_power,
   input  logic [7:0]  req_driven_cap_key,
   input  logic [7:0]  req_out_slew_key,
   input  logic [7:0]  req_load_cap_key,
   input  logic [7:0]  req_in_slew_key,
   input  logic [31:0] req_pattern_key,
   input  logic [3:0]  req_group_num,
   input  logic        req_last_entry,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_entry_slot,
   output logic [3:0]  rsp_entry_group,
   output logic [31:0] rsp_entry_delay,
   output logic [31:0] rsp_entry_power,
   output logic [6:0]  rsp_front_count,
   output logic [31:0] rsp_front_least_delay,
   output logic        rsp_last_result
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int SW = $clog2(MAX_ENTRIES);
   localparam int GW = $clog2(dpps_pkg::NUM_GROUPS + 1);
   localparam int LW = $clog2(dpps_pkg::NUM_GROUPS);

   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_COUNT = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   state_type state_ff;
   logic      mode_ff;
   logic [CW-1:0] cnt_ff, n_ff, k_ff;
   logic [SW-1:0] step_ff;
   logic [31:0]   least_ff;
   logic [dpps_pkg::NUM_GROUPS-1:0] seen_ff;
   logic [dpps_pkg::GROUP_W-1:0]    grp_list_ff [dpps_pkg::NUM_GROUPS];
   logic [GW-1:0] ngroups_ff, grp_idx_ff, groups_used;

   logic rsp_valid_ff, rsp_last_ff;
   logic [5:0]  rsp_slot_ff;
   logic [3:0]  rsp_group_ff;
   logic [31:0] rsp_delay_ff, rsp_power_ff, rsp_least_ff;
   logic [6:0]  rsp_count_ff;

   dpps_pkg::entry_type     new_entry, head;
   dpps_pkg::entry_type     own [MAX_ENTRIES];
   logic                    ins [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]  valid_vec;
   dpps_pkg::cell_ctrl_type ctrl;

   logic accept, store, advance, take, last_step, on_front, last_group, scan_clear;
   logic [dpps_pkg::GROUP_W-1:0] cur_group;
   logic [CW-1:0] median;

   assign req_stall = (state_ff != ST_LOAD);
   assign accept    = req_valid && !req_stall;
   assign store     = accept && (cnt_ff < CW'(MAX_ENTRIES));

   always_comb begin
      new_entry.valid      = 1'b1;
      new_entry.slot       = dpps_pkg::SLOT_W'(cnt_ff);
      new_entry.group      = req_group_num;
      new_entry.delay      = req_delay;
      new_entry.power      = req_power;
      new_entry.driven_cap = req_driven_cap_key;
      new_entry.out_slew   = req_out_slew_key;
      new_entry.load_cap   = req_load_cap_key;
      new_entry.in_slew    = req_in_slew_key;
      new_entry.pattern    = req_pattern_key;
   end

   // chain: cell 0 is the head; rotation moves every entry one cell toward the head
   genvar gi;
   generate
      for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
         dpps_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .new_entry  (new_entry),
            .prev_entry ((gi == 0) ? new_entry : own[(gi == 0) ? 0 : gi - 1]),
            .prev_ins   ((gi == 0) ? 1'b0 : ins[(gi == 0) ? 0 : gi - 1]),
            .next_entry (own[(gi + 1) % MAX_ENTRIES]),
            .own_entry  (own[gi]),
            .ins        (ins[gi])
         );
         assign valid_vec[gi] = own[gi].valid;
      end
   endgenerate

   assign head        = own[0];
   assign groups_used = (7'(ngroups_ff) > 7'(MAX_GROUPS)) ? GW'(MAX_GROUPS) : ngroups_ff;
   assign cur_group   = grp_list_ff[grp_idx_ff[LW-1:0]];
   assign last_step   = (step_ff == SW'(MAX_ENTRIES - 1));
   assign last_group  = ((grp_idx_ff + GW'(1)) == groups_used);
   assign median      = (n_ff - CW'(1)) >> 1;

   // the emit pass waits while a finished result is still stalled
   assign advance = (state_ff == ST_COUNT) ||
                    ((state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall));
   assign take    = advance && head.valid && (!mode_ff || head.group == cur_group);
   assign scan_clear = advance && last_step;

   always_comb begin
      ctrl.load   = store;
      ctrl.rotate = advance;
      ctrl.clear  = (state_ff == ST_EMIT) && scan_clear && !(mode_ff && !last_group);
   end

   dpps_front_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .clear    (scan_clear),
      .take     (take),
      .delay    (head.delay),
      .power    (head.power),
      .on_front (on_front)
   );

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         mode_ff    <= 1'b0;
         cnt_ff     <= '0;
         n_ff       <= '0;
         k_ff       <= '0;
         step_ff    <= '0;
         seen_ff    <= '0;
         ngroups_ff <= '0;
         grp_idx_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (advance) begin
            step_ff <= last_step ? '0 : step_ff + SW'(1);
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (store) begin
                  cnt_ff <= cnt_ff + CW'(1);
                  if (!seen_ff[req_group_num]) begin
                     seen_ff[req_group_num] <= 1'b1;
                     ngroups_ff             <= ngroups_ff + GW'(1);
                  end
               end
               if (accept && req_last_entry) begin
                  state_ff   <= ST_COUNT;
                  n_ff       <= '0;
                  grp_idx_ff <= '0;
               end
            end
            ST_COUNT: begin
               if (take && on_front) begin
                  n_ff <= n_ff + CW'(1);
               end
               if (last_step) begin
                  state_ff <= ST_EMIT;
                  k_ff     <= '0;
               end
            end
            ST_EMIT: begin
               if (take && on_front) begin
                  k_ff <= k_ff + CW'(1);
               end
               if (advance && last_step) begin
                  if (mode_ff && !last_group) begin
                     grp_idx_ff <= grp_idx_ff + GW'(1);
                     n_ff       <= '0;
                     state_ff   <= ST_COUNT;
                  end else begin
                     cnt_ff     <= '0;
                     seen_ff    <= '0;
                     ngroups_ff <= '0;
                     state_ff   <= ST_LOAD;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   // group list in order of first appearance
   always_ff @(posedge clock) begin
      if (store && !seen_ff[req_group_num]) begin
         grp_list_ff[ngroups_ff[LW-1:0]] <= req_group_num;
      end
   end

   // least front delay, gathered in the count pass
   always_ff @(posedge clock) begin
      if (state_ff == ST_COUNT && take && on_front) begin
         if (n_ff == '0 || head.delay < least_ff) begin
            least_ff <= head.delay;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_EMIT && take && on_front &&
                   (mode_ff || k_ff == median)) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && take && on_front && (mode_ff || k_ff == median)) begin
         rsp_slot_ff  <= head.slot;
         rsp_group_ff <= head.group;
         rsp_delay_ff <= head.delay;
         rsp_power_ff <= head.power;
         rsp_count_ff <= dpps_pkg::COUNT_OUT_W'(n_ff);
         rsp_least_ff <= least_ff;
         rsp_last_ff  <= !mode_ff || ((k_ff == n_ff - CW'(1)) && last_group);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_entry_slot        = rsp_slot_ff;
   assign rsp_entry_group       = rsp_group_ff;
   assign rsp_entry_delay       = rsp_delay_ff;
   assign rsp_entry_power       = rsp_power_ff;
   assign rsp_front_count       = rsp_count_ff;
   assign rsp_front_least_delay = rsp_least_ff;
   assign rsp_last_result       = rsp_last_ff;

   // stored entries sit in a contiguous prefix of the chain while loading
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (((valid_vec >> 1) & ~valid_vec) == '0))
      else $error("chain valid bits not a prefix");

   a_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> ($countones(valid_vec) == int'(cnt_ff)))
      else $error("entry count disagrees with chain");

   a_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_ENTRIES))
      else $error("entry count past capacity");

endmodule

[rtl/dpps_cell.sv]
module dpps_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  dpps_pkg::cell_ctrl_type ctrl,
   input  dpps_pkg::entry_type     new_entry,
   input  dpps_pkg::entry_type     prev_entry,
   input  logic                    prev_ins,
   input  dpps_pkg::entry_type     next_entry,
   output dpps_pkg::entry_type     own_entry,
   output logic                    ins
);

   dpps_pkg::entry_type entry_ff;

   // new entry lands here or pushes this one down
   assign ins       = !entry_ff.valid || dpps_pkg::goes_before(new_entry, entry_ff);
   assign own_entry = entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (ctrl.clear) begin
         entry_ff.valid <= 1'b0;
      end else if (ctrl.load && ins) begin
         entry_ff <= prev_ins ? prev_entry : new_entry;
      end else if (ctrl.rotate) begin
         entry_ff <= next_entry;
      end
   end

endmodule

[rtl/dpps_front_scan.sv]
module dpps_front_scan (
   input  logic        clock,
   input  logic        reset,
   input  logic        clear,
   input  logic        take,
   input  logic [31:0] delay,
   input  logic [31:0] power,
   output logic        on_front
);

   logic        have_run_ff, min_vld_ff;
   logic [31:0] run_power_ff, run_delay_ff, min_ff;
   logic        new_run, mp_vld;
   logic [31:0] mp, rf;

   always_comb begin
      new_run = !have_run_ff || (power != run_power_ff);
      rf      = new_run ? delay : run_delay_ff;
      if (new_run) begin
         mp_vld = have_run_ff;
         mp     = (min_vld_ff && min_ff < run_delay_ff) ? min_ff : run_delay_ff;
      end else begin
         mp_vld = min_vld_ff;
         mp     = min_ff;
      end
      on_front = (delay == rf) && (!mp_vld || delay < mp);
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         have_run_ff <= 1'b0;
         min_vld_ff  <= 1'b0;
      end else if (take) begin
         have_run_ff  <= 1'b1;
         min_vld_ff   <= mp_vld;
         run_power_ff <= power;
         run_delay_ff <= rf;
         min_ff       <= mp;
      end
   end

endmodule

[bench/tb_delay_power_pareto_selector.sv]
`timescale 1ns / 1ps

module tb_delay_power_pareto_selector;

   localparam int MAX_ENTRIES = 64;
   localparam int MAX_GROUPS  = 16;

   // one input beat
   typedef struct {
      logic [31:0] delay;
      logic [31:0] power;
      logic [7:0]  driven_cap;
      logic [7:0]  out_slew;
      logic [7:0]  load_cap;
      logic [7:0]  in_slew;
      logic [31:0] pattern;
      logic [3:0]  group;
      logic        last;
   } cand_type;

   // one result beat
   typedef struct {
      logic [5:0]  slot;
      logic [3:0]  group;
      logic [31:0] delay;
      logic [31:0] power;
      logic [6:0]  count;
      logic [31:0] least;
      logic        last;
   } pick_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic        csr_wr_data = 0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [31:0] req_delay = 0;
   logic [31:0] req_power = 0;
   logic [7:0]  req_driven_cap_key = 0;
   logic [7:0]  req_out_slew_key = 0;
   logic [7:0]  req_load_cap_key = 0;
   logic [7:0]  req_in_slew_key = 0;
   logic [31:0] req_pattern_key = 0;
   logic [3:0]  req_group_num = 0;
   logic        req_last_entry = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [5:0]  rsp_entry_slot;
   logic [3:0]  rsp_entry_group;
   logic [31:0] rsp_entry_delay;
   logic [31:0] rsp_entry_power;
   logic [6:0]  rsp_front_count;
   logic [31:0] rsp_front_least_delay;
   logic        rsp_last_result;

   delay_power_pareto_selector dut (.*);

   always #1 clock = ~clock;

   // predictor state: candidate store, fill level and mode
   cand_type    cand_store [MAX_ENTRIES];
   int          cand_fill;
   logic        pick_mode;

   cand_type    pending_cands [$];
   pick_type    expected_picks [$];
   int          errors;
   int          idle_pct;
   int          stall_pct;

   // true when slot a precedes slot b on the front
   function automatic bit ranks_ahead(int a, int b);
      cand_type x, y;
      x = cand_store[a];
      y = cand_store[b];
      if (x.power != y.power)           return x.power < y.power;
      if (x.delay != y.delay)           return x.delay < y.delay;
      if (x.driven_cap != y.driven_cap) return x.driven_cap < y.driven_cap;
      if (x.out_slew != y.out_slew)     return x.out_slew < y.out_slew;
      if (x.load_cap != y.load_cap)     return x.load_cap < y.load_cap;
      if (x.in_slew != y.in_slew)       return x.in_slew > y.in_slew;
      if (x.pattern != y.pattern)       return x.pattern < y.pattern;
      return a < b;
   endfunction

   // build the ordered front of the whole store or of one group
   function automatic int collect_front(bit by_group, logic [3:0] grp, ref int list[$],
                                        ref logic [31:0] least);
      bit beaten;
      int k;
      list = {};
      least = '1;
      for (int i = 0; i < cand_fill; i++) begin
         if (by_group && cand_store[i].group != grp) continue;
         beaten = 0;
         for (int j = 0; j < cand_fill; j++) begin
            if (by_group && cand_store[j].group != grp) continue;
            if ((cand_store[j].delay <= cand_store[i].delay &&
                 cand_store[j].power < cand_store[i].power) ||
                (cand_store[j].delay < cand_store[i].delay &&
                 cand_store[j].power <= cand_store[i].power))
               beaten = 1;
         end
         if (beaten) continue;
         if (cand_store[i].delay < least) least = cand_store[i].delay;
         k = list.size();
         while (k > 0 && ranks_ahead(i, list[k-1])) k--;
         list.insert(k, i);
      end
      return list.size();
   endfunction

   function automatic pick_type make_pick(int s, int n, logic [31:0] least);
      pick_type p;
      p.slot  = s[5:0];
      p.group = cand_store[s].group;
      p.delay = cand_store[s].delay;
      p.power = cand_store[s].power;
      p.count = n[6:0];
      p.least = least;
      p.last  = 0;
      return p;
   endfunction

   // store one accepted candidate; on the last one, queue the picks
   task automatic predict_picks(cand_type c);
      int list[$];
      logic [31:0] least;
      int n, groups;
      bit seen;
      pick_type run [$];
      if (cand_fill < MAX_ENTRIES) begin
         cand_store[cand_fill] = c;
         cand_fill++;
      end
      if (!c.last) return;
      if (pick_mode == 0) begin
         n = collect_front(0, 0, list, least);
         if (n > 0) run.insert(run.size(), make_pick(list[(n-1)/2], n, least));
      end else begin
         groups = 0;
         for (int i = 0; i < cand_fill; i++) begin
            seen = 0;
            for (int j = 0; j < i; j++)
               if (cand_store[j].group == cand_store[i].group) seen = 1;
            if (seen || groups >= MAX_GROUPS) continue;
            groups++;
            n = collect_front(1, cand_store[i].group, list, least);
            for (int k = 0; k < n; k++)
               if (run.size() < MAX_ENTRIES)
                  run.insert(run.size(), make_pick(list[k], n, least));
         end
      end
      if (run.size() > 0) run[run.size()-1].last = 1;
      foreach (run[i]) expected_picks.insert(expected_picks.size(), run[i]);
      cand_fill = 0;
   endtask

   // driver: present the next pending beat, hold it while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) predict_picks(pending_cands[0]);
         if (req_valid) void'(pending_cands.pop_front());
         if (pending_cands.size() > 0 && $urandom_range(99) >= idle_pct) begin
            cand_type c;
            c = pending_cands[0];
            req_valid          <= 1;
            req_delay          <= c.delay;
            req_power          <= c.power;
            req_driven_cap_key <= c.driven_cap;
            req_out_slew_key   <= c.out_slew;
            req_load_cap_key   <= c.load_cap;
            req_in_slew_key    <= c.in_slew;
            req_pattern_key    <= c.pattern;
            req_group_num      <= c.group;
            req_last_entry     <= c.last;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // monitor: compare each accepted result beat, then redraw the stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_picks.size() == 0) begin
               $error("unexpected result beat, slot %0d", rsp_entry_slot);
               errors++;
            end else begin
               pick_type e;
               e = expected_picks.pop_front();
               if (rsp_entry_slot !== e.slot) begin
                  $error("entry_slot exp %0d got %0d", e.slot, rsp_entry_slot); errors++;
               end
               if (rsp_entry_group !== e.group) begin
                  $error("entry_group exp %0d got %0d", e.group, rsp_entry_group); errors++;
               end
               if (rsp_entry_delay !== e.delay) begin
                  $error("entry_delay exp %h got %h", e.delay, rsp_entry_delay); errors++;
               end
               if (rsp_entry_power !== e.power) begin
                  $error("entry_power exp %h got %h", e.power, rsp_entry_power); errors++;
               end
               if (rsp_front_count !== e.count) begin
                  $error("front_count exp %0d got %0d", e.count, rsp_front_count); errors++;
               end
               if (rsp_front_least_delay !== e.least) begin
                  $error("front_least_delay exp %h got %h", e.least, rsp_front_least_delay);
                  errors++;
               end
               if (rsp_last_result !== e.last) begin
                  $error("last_result exp %0d got %0d", e.last, rsp_last_result); errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic cand_type rand_cand(int set_len, int idx, int style);
      cand_type c;
      c.delay      = $urandom();
      c.power      = $urandom();
      // narrow ranges force dominance, ties and equal-delay groups
      if (style == 1) begin
         c.delay = $urandom_range(7);
         c.power = $urandom_range(7);
      end else if (style == 2) begin
         c.delay = {$urandom_range(1) != 0, 30'h0, $urandom_range(1) != 0};
         c.power = {$urandom_range(1) != 0, 30'h0, $urandom_range(1) != 0};
      end
      c.driven_cap = 8'((style != 0) ? $urandom_range(1) * 255 : $urandom());
      c.out_slew   = 8'((style != 0) ? $urandom_range(1) * 255 : $urandom());
      c.load_cap   = 8'((style != 0) ? $urandom_range(1) * 255 : $urandom());
      c.in_slew    = 8'((style != 0) ? $urandom_range(1) * 255 : $urandom());
      c.pattern    = (style != 0) ? $urandom_range(1) : $urandom();
      c.group      = 4'((style == 1) ? $urandom_range(3) : $urandom());
      c.last       = (idx == set_len - 1);
      return c;
   endfunction

   // queue one set and wait until it has drained
   task automatic run_set(int set_len, int style);
      for (int i = 0; i < set_len; i++)
         pending_cands.insert(pending_cands.size(), rand_cand(set_len, i, style));
      wait (pending_cands.size() == 0 && !req_valid);
      wait (expected_picks.size() == 0);
      // let the remaining passes of the chain finish
      repeat (2 * MAX_ENTRIES * (MAX_GROUPS + 1) + 20) @(posedge clock);
   endtask

   task automatic write_mode(logic m);
      @(posedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= m;
      pick_mode   = m;
      @(posedge clock);
      csr_wr_en   <= 0;
   endtask

   initial begin
      cand_type c;
      errors = 0;
      cand_fill = 0;
      pick_mode = 0;
      idle_pct = 0;
      stall_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 0;

      // directed: single entry, extremes, full ties, mode 0 then mode 1
      c = '{32'hffffffff, 32'hffffffff, 8'hff, 8'hff, 8'hff, 8'hff, 32'hffffffff, 4'hf, 1};
      pending_cands.insert(pending_cands.size(), c);
      run_set(0, 0);
      c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      pending_cands.insert(pending_cands.size(), c);
      pending_cands.insert(pending_cands.size(), c);
      c.last = 1;
      pending_cands.insert(pending_cands.size(), c);
      run_set(0, 0);
      write_mode(1);
      c = '{5, 5, 1, 2, 3, 4, 9, 4'ha, 0};
      pending_cands.insert(pending_cands.size(), c);
      c = '{5, 5, 1, 2, 3, 200, 9, 4'ha, 0};
      pending_cands.insert(pending_cands.size(), c);
      c = '{3, 9, 0, 0, 0, 0, 0, 4'h3, 0};
      pending_cands.insert(pending_cands.size(), c);
      c = '{3, 9, 0, 0, 0, 0, 0, 4'ha, 1};
      pending_cands.insert(pending_cands.size(), c);
      run_set(0, 0);
      // overfill: entries past the store size are dropped
      run_set(MAX_ENTRIES + 3, 1);
      // seventeen entries in one set; the last wraps back to group 0
      for (int g = 0; g < 17; g++) begin
         c = '{$urandom(), $urandom(), 0, 0, 0, 0, 0, g[3:0], g == 16};
         pending_cands.insert(pending_cands.size(), c);
      end
      run_set(0, 0);

      // random sets through the idling phases and both modes
      for (int ph = 0; ph < 6; ph++) begin
         int ph_sent;
         ph_sent = 0;
         unique case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 78; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 78; end
            default: begin idle_pct = 17; stall_pct = 17; end
         endcase
         write_mode(ph[0] ^ ph[2]);
         while (ph_sent < 24) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(MAX_ENTRIES - 10, MAX_ENTRIES)
                                           : $urandom_range(1, 8);
            run_set(len, $urandom_range(2));
            ph_sent += len;
         end
      end

      if (errors == 0 && expected_picks.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

[delay_power_pareto_selector.f]
rtl/dpps_pkg.sv
rtl/dpps_cell.sv
rtl/dpps_front_scan.sv
rtl/delay_power_pareto_selector.sv
bench/tb_delay_power_pareto_selector.sv
